// ===== sv/resbk_pkg.sv =====
// Shared types and constants for the record exchange sorter.
`timescale 1ns / 1ps
`default_nettype none

package resbk_pkg;

   localparam int KEY_W  = 12;
   localparam int TAG_W  = 8;
   localparam int DATA_W = 32;
   localparam int PADDR_W = 3;

   // Register byte addresses.
   localparam logic [PADDR_W-1:0] REG_ORDER_DESCENDING = 3'd0;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } record_type;

   // Result of one compare-and-exchange step.
   typedef struct packed {
      logic       swap;
      record_type keep;
   } cmp_result_type;

endpackage

`default_nettype wire

// ===== sv/resbk_req_if.sv =====
// Input channel interface carrying one record per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface resbk_req_if import resbk_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] score_key;
   logic [TAG_W-1:0] record_tag;
   logic             end_of_set;

   modport source (output valid, score_key, record_tag, end_of_set, input ready);
   modport sink (input valid, score_key, record_tag, end_of_set, output ready);
endinterface

`default_nettype wire

// ===== sv/resbk_rsp_if.sv =====
// Result channel interface carrying one sorted record per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface resbk_rsp_if import resbk_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] sorted_key;
   logic [TAG_W-1:0] sorted_tag;
   logic             run_last;
   logic             overflowed;

   modport source (output valid, sorted_key, sorted_tag, run_last, overflowed, input ready);
   modport sink (input valid, sorted_key, sorted_tag, run_last, overflowed, output ready);
endinterface

`default_nettype wire

// ===== sv/record_exchange_sort_by_key_unit.sv =====
// Top level of the record exchange sorter: sequencer, register port and output stage.
`timescale 1ns / 1ps
`default_nettype none

// Records (a 12-bit unsigned 8.4 score and an 8-bit tag) are loaded one per
// transaction, one per cycle, into an on-chip store of MAX_RECORDS entries.
// Records that arrive while the store is full are dropped and the set is
// marked as overflowed; the record flagged end_of_set is dropped the same
// way if the store is full. When end_of_set arrives the input stops taking
// transactions and the stored records are put in order by an exchange sort:
// for each position i and every later position j the pair is swapped when
// strictly out of order, so ties land exactly where that procedure puts
// them. The direction comes from register order_descending (byte address 0,
// reset 1, highest score first). Every record of the sorted run is then
// sent out, with run_last on the final one and overflowed on all of them
// when the set lost records. The sort takes one pair at a time, as the
// single store read port and the one compare unit are shared; each record
// leaves through a read state and a load state, the read waiting while
// the output register is full. Loading of the next set begins while the
// last result of a run may still wait in the output register. The user must
// write configuration only while no set is in flight; no check enforces it.

module record_exchange_sort_by_key_unit
   import resbk_pkg::*;
#(
   parameter int MAX_RECORDS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   resbk_req_if.sink                req_bus,
   resbk_rsp_if.source              rsp_bus,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [PADDR_W-1:0]  csr_paddr,
   input  wire logic [DATA_W-1:0]   csr_pwdata,
   output      logic [DATA_W-1:0]   csr_prdata,
   output      logic                csr_pready
);

   localparam int ADDR_W = $clog2(MAX_RECORDS);
   localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_RECORDS);

   typedef enum logic [7:0] {
      ST_LOAD     = 8'b0000_0001,
      ST_FETCH_I  = 8'b0000_0010,
      ST_HOLD_I   = 8'b0000_0100,
      ST_FETCH_J  = 8'b0000_1000,
      ST_CMP      = 8'b0001_0000,
      ST_STORE_I  = 8'b0010_0000,
      ST_EMIT_RD  = 8'b0100_0000,
      ST_EMIT_LD  = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] k_ff, k_in;
   record_type       cur_ff, cur_in;
   logic             order_ff, order_in;

   logic             rsp_valid_ff, rsp_valid_in;
   record_type       rsp_rec_ff, rsp_rec_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;
   logic             rsp_load;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   record_type        wr_data;
   logic [ADDR_W-1:0] rd_addr;
   record_type        rd_data;
   cmp_result_type    cmp_res;
   logic              req_take;
   logic              csr_write;

   resbk_store #(
      .DEPTH (MAX_RECORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   resbk_cmp u_cmp (
      .order_descending (order_ff),
      .held             (cur_ff),
      .probe            (rd_data),
      .result           (cmp_res)
   );

   // Register port: a single direction bit, always ready.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      order_in = order_ff;
      if (csr_write && (csr_paddr == REG_ORDER_DESCENDING)) begin
         order_in = csr_pwdata[0];
      end
      if (csr_paddr == REG_ORDER_DESCENDING) begin
         csr_prdata = {{(DATA_W-1){1'b0}}, order_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   assign req_bus.ready = (state_ff == ST_LOAD);
   assign req_take      = req_bus.valid && req_bus.ready;

   // Sequencer for load, sort and emission.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = cur_ff;
      rd_addr      = '0;
      rsp_load     = 1'b0;
      rsp_rec_in   = rd_data;
      rsp_last_in  = (k_ff + CNT_W'(1)) == count_ff;
      rsp_ovf_in   = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (count_ff < FULL_COUNT) begin
                  wr_en       = 1'b1;
                  wr_addr     = count_ff[ADDR_W-1:0];
                  wr_data.key = req_bus.score_key;
                  wr_data.tag = req_bus.record_tag;
                  count_in    = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_bus.end_of_set) begin
                  i_in = '0;
                  k_in = '0;
                  if (count_in >= CNT_W'(2)) begin
                     state_in = ST_FETCH_I;
                  end else begin
                     state_in = ST_EMIT_RD;
                  end
               end
            end
         end
         ST_FETCH_I: begin
            rd_addr  = i_ff[ADDR_W-1:0];
            state_in = ST_HOLD_I;
         end
         ST_HOLD_I: begin
            cur_in   = rd_data;
            j_in     = i_ff + CNT_W'(1);
            state_in = ST_FETCH_J;
         end
         ST_FETCH_J: begin
            rd_addr  = j_ff[ADDR_W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // The held record moves to j when the pair is out of order.
            cur_in  = cmp_res.keep;
            wr_en   = cmp_res.swap;
            wr_addr = j_ff[ADDR_W-1:0];
            wr_data = cur_ff;
            if ((j_ff + CNT_W'(1)) < count_ff) begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_FETCH_J;
            end else begin
               state_in = ST_STORE_I;
            end
         end
         ST_STORE_I: begin
            wr_en   = 1'b1;
            wr_addr = i_ff[ADDR_W-1:0];
            wr_data = cur_ff;
            i_in    = i_ff + CNT_W'(1);
            if ((i_ff + CNT_W'(2)) < count_ff) begin
               state_in = ST_FETCH_I;
            end else begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            // Read ahead only when the output register will be free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rd_addr  = k_ff[ADDR_W-1:0];
               state_in = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            rsp_load     = 1'b1;
            rsp_valid_in = 1'b1;
            if (rsp_last_in) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         order_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      cur_ff <= cur_in;
      if (rsp_load) begin
         rsp_rec_ff  <= rsp_rec_in;
         rsp_last_ff <= rsp_last_in;
         rsp_ovf_ff  <= rsp_ovf_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sorted_key = rsp_rec_ff.key;
   assign rsp_bus.sorted_tag = rsp_rec_ff.tag;
   assign rsp_bus.run_last   = rsp_last_ff;
   assign rsp_bus.overflowed = rsp_ovf_ff;

endmodule

`default_nettype wire

// ===== sv/resbk_store.sv =====
// Record memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module resbk_store
   import resbk_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire record_type                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      record_type                 rd_data
);

   record_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/resbk_cmp.sv =====
// Compare-and-exchange unit shared by every step of the sort.
`timescale 1ns / 1ps
`default_nettype none

module resbk_cmp
   import resbk_pkg::*;
(
   input  wire logic       order_descending,
   input  wire record_type held,
   input  wire record_type probe,
   output      cmp_result_type result
);

   logic swap;

   // Equal keys never swap, which fixes the order of ties.
   always_comb begin
      if (order_descending) begin
         swap = held.key < probe.key;
      end else begin
         swap = held.key > probe.key;
      end
      result.swap = swap;
      result.keep = swap ? probe : held;
   end

endmodule

`default_nettype wire
